[sv/modified_utf7_to_utf8_decoder_core_assert.svh]
// Assertion macros used by the decoder's top-level RTL file.
`ifndef MODIFIED_UTF7_TO_UTF8_DECODER_CORE_ASSERT_SVH
`define MODIFIED_UTF7_TO_UTF8_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MU7U8_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");

// Next-cycle implication, checked outside reset.
`define MU7U8_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");

// Checked during reset as well.
`define MU7U8_ASSERT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("decoder check failed");

`endif

[sv/mu7u8_pkg.sv]
// Types, constants and helper functions shared by the decoder modules.
package mu7u8_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_AMP   = 2'd1,
    MODE_B64   = 2'd2
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One queued job: up to three output bytes caused by one input byte.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       has_byte;
    logic       eos;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Returns {valid, value} of a base64 digit of the modified alphabet.
  function automatic logic [6:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h41 && c <= 8'h5a) begin
        d = c - 8'h41;
        return {1'b1, d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7a) begin
        d = c - 8'h61 + 8'd26;
        return {1'b1, d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30 + 8'd52;
        return {1'b1, d[5:0]};
      end else if (c == CH_PLUS) begin
        return {1'b1, 6'd62};
      end else if (c == CH_COMMA) begin
        return {1'b1, 6'd63};
      end
      return 7'd0;
    end
  endfunction

  // UTF-8 bytes of a 16-bit unit; a zero unit gives no bytes.
  function automatic job_t utf8_job(input logic [15:0] x);
    job_t j;
    begin
      j = '0;
      j.has_byte = 1'b1;
      if (x == 16'h0000) begin
        j.cnt = 2'd0;
      end else if (x <= 16'h007f) begin
        j.b0  = x[7:0];
        j.cnt = 2'd1;
      end else if (x <= 16'h07ff) begin
        j.b0  = 8'hc0 | {3'b000, x[10:6]};
        j.b1  = 8'h80 | {2'b00, x[5:0]};
        j.cnt = 2'd2;
      end else begin
        j.b0  = 8'he0 | {4'b0000, x[15:12]};
        j.b1  = 8'h80 | {2'b00, x[11:6]};
        j.b2  = 8'h80 | {2'b00, x[5:0]};
        j.cnt = 2'd3;
      end
      return j;
    end
  endfunction

endpackage

[sv/mu7u8_front.sv]
// Front end: accepts input bytes, tracks the shift state and builds output jobs.
module mu7u8_front import mu7u8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  qstat_t     qstat,
  output logic       in_stall,
  output logic       push,
  output job_t       push_job
);

  mode_t       mode;
  mode_t       mode_next;
  logic [19:0] bbuf;
  logic [19:0] bbuf_next;
  logic [4:0]  bcnt;
  logic [4:0]  bcnt_next;

  logic        accept;
  logic [6:0]  dig;
  logic        is_dig;
  logic [19:0] buf_shift;
  logic [4:0]  cnt_add;
  logic [4:0]  cnt_sub;
  logic [15:0] unit;
  job_t        job;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign dig      = digit_value(in_byte);
  assign is_dig   = dig[6];

  assign buf_shift = {bbuf[13:0], dig[5:0]};
  assign cnt_add   = bcnt + 5'd6;
  assign cnt_sub   = cnt_add - 5'd16;
  assign unit      = 16'(buf_shift >> cnt_sub[2:0]);

  // Next shift state and bit buffer.
  always_comb begin
    mode_next = mode;
    bbuf_next = bbuf;
    bcnt_next = bcnt;
    if (in_byte == CH_NUL) begin
      mode_next = MODE_PLAIN;
      bbuf_next = '0;
      bcnt_next = '0;
    end else begin
      case (mode)
        MODE_AMP: begin
          if (in_byte == CH_DASH) begin
            mode_next = MODE_PLAIN;
          end else if (is_dig) begin
            bbuf_next = {14'd0, dig[5:0]};
            bcnt_next = 5'd6;
            mode_next = MODE_B64;
          end else begin
            mode_next = MODE_PLAIN;
          end
        end
        MODE_B64: begin
          if (in_byte == CH_DASH) begin
            mode_next = MODE_PLAIN;
          end else if (is_dig) begin
            bbuf_next = buf_shift;
            bcnt_next = (cnt_add >= 5'd16) ? cnt_sub : cnt_add;
          end else begin
            mode_next = MODE_PLAIN;
          end
        end
        default: begin
          mode_next = (in_byte == CH_AMP) ? MODE_AMP : MODE_PLAIN;
        end
      endcase
    end
  end

  // Job produced by the current byte.
  always_comb begin
    job = '0;
    job.has_byte = 1'b1;
    if (in_byte == CH_NUL) begin
      job.eos = 1'b1;
      if (mode == MODE_AMP) begin
        job.b0  = CH_AMP;
        job.b1  = CH_DASH;
        job.cnt = 2'd2;
      end else begin
        job.has_byte = 1'b0;
        job.cnt      = 2'd1;
      end
    end else begin
      case (mode)
        MODE_AMP: begin
          if (in_byte == CH_DASH) begin
            job.b0  = CH_AMP;
            job.cnt = 2'd1;
          end else if (!is_dig) begin
            job.b0  = CH_AMP;
            job.b1  = CH_DASH;
            job.cnt = 2'd2;
          end
        end
        MODE_B64: begin
          if (in_byte == CH_DASH) begin
            job.cnt = 2'd0;
          end else if (is_dig) begin
            if (cnt_add >= 5'd16) begin
              job = utf8_job(unit);
            end
          end else begin
            job = utf8_job({8'h00, in_byte});
          end
        end
        default: begin
          if (in_byte != CH_AMP) begin
            job.b0  = in_byte;
            job.cnt = 2'd1;
          end
        end
      endcase
    end
  end

  assign push     = accept && (job.cnt != 2'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      bbuf <= '0;
      bcnt <= '0;
    end else if (accept) begin
      mode <= mode_next;
      bbuf <= bbuf_next;
      bcnt <= bcnt_next;
    end
  end

endmodule

[sv/mu7u8_fifo.sv]
// Short job queue between the front end and the byte serializer.
module mu7u8_fifo import mu7u8_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  job_t   push_job,
  input  logic   pop,
  output job_t   head,
  output qstat_t qstat
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/mu7u8_back.sv]
// Back end: takes jobs from the queue and sends their bytes one per transfer.
module mu7u8_back import mu7u8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  qstat_t     qstat,
  output logic       pop,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_string
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       load;
  logic       last;
  logic [7:0] sel;

  assign load = cur_valid && (!out_valid || !out_stall);
  assign last = (idx == cur.cnt - 2'd1);
  // A new job is fetched as soon as the current one hands over its last byte.
  assign pop  = !qstat.empty && (!cur_valid || (load && last));

  always_comb begin
    case (idx)
      2'd0:    sel = cur.b0;
      2'd1:    sel = cur.b1;
      2'd2:    sel = cur.b2;
      default: sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (load && last) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= sel;
      has_byte      <= cur.has_byte;
      end_of_string <= cur.eos && last;
    end
  end

endmodule

[sv/modified_utf7_to_utf8_decoder_core.sv]
// Top level of the modified UTF-7 to UTF-8 decoder.
//
//   channel | ports                                     | direction
//   input   | in_valid, in_stall, in_byte               | bytes in
//   output  | out_valid, out_stall, out_byte, has_byte, | UTF-8 bytes out
//           | end_of_string                             |
//
// Each byte is classified as it transfers; the front end takes one per cycle unless stalled.
// Each byte gives 0 to 3 output bytes, sent one per cycle by the serializer while out_stall is low,
// so the sustained rate is set by the output byte count.
// A four-entry job queue sits between the two; in_stall rises only when it is full.
// An output byte passes through the queue, the current-job register and the output register.
// Synchronous reset clears the shift state, the queue and the output valid flag.
module modified_utf7_to_utf8_decoder_core import mu7u8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_string
);

`include "modified_utf7_to_utf8_decoder_core_assert.svh"

  qstat_t qstat;
  logic   push;
  logic   pop;
  job_t   push_job;
  job_t   head;

  mu7u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .qstat    (qstat),
    .in_stall (in_stall),
    .push     (push),
    .push_job (push_job)
  );

  mu7u8_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  mu7u8_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .has_byte      (has_byte),
    .end_of_string (end_of_string)
  );

  // The queue never takes a job while full and never gives one while empty.
  `MU7U8_ASSERT_IMPLY(a_no_overflow, push, !qstat.full)
  `MU7U8_ASSERT_IMPLY(a_no_underflow, pop, !qstat.empty)
  // A bare marker is always the end of a string and carries a zero byte.
  `MU7U8_ASSERT_IMPLY(a_bare_marker, out_valid && !has_byte,
                      end_of_string && (out_byte == 8'h00))
  // Nothing is offered on the output right after reset.
  `MU7U8_ASSERT_ALWAYS(a_reset_quiet, $past(rst), !out_valid)

endmodule
